// ===== rtl/ols_pkg.sv =====
// ----------------------------------------------------------------------------
// ols_pkg
// Shared constants, opcodes and types of the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

	// list capacity and derived widths
	localparam int DEPTH     = 16;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int POS_W     = 5;
	localparam int FIDX_W    = 4;
	localparam int COUNT_W   = 5;
	localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

	// opcodes
	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	// one result item
	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] read_data;
		logic [FIDX_W-1:0]        found_index;
		logic [COUNT_W-1:0]       count;
	} res_t;

	// access request from the sequencer to the entry memory
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

endpackage

// ===== rtl/ols_if.sv =====
// ----------------------------------------------------------------------------
// ols_if
// Valid/ready channels of the ordered list store: request and response.
// ----------------------------------------------------------------------------
interface ols_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [ols_pkg::OP_W-1:0]             opcode;
	logic [ols_pkg::POS_W-1:0]            position;
	logic signed [ols_pkg::DATA_W-1:0]    value;

	modport source (output valid, output opcode, output position, output value, input ready);
	modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface ols_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 ok;
	logic signed [ols_pkg::DATA_W-1:0]    read_data;
	logic [ols_pkg::FIDX_W-1:0]           found_index;
	logic [ols_pkg::COUNT_W-1:0]          count;

	modport source (output valid, output ok, output read_data, output found_index,
		output count, input ready);
	modport sink   (input valid, input ok, input read_data, input found_index,
		input count, output ready);
endinterface

// ===== rtl/ols_ram.sv =====
// ----------------------------------------------------------------------------
// ols_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ols_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ols_ctrl.sv =====
// ----------------------------------------------------------------------------
// ols_ctrl
// Operation sequencer: decodes an item, walks the entry memory one entry per
// cycle for shifts and searches, keeps the count and the result register.
// ----------------------------------------------------------------------------
module ols_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	ols_req_if.sink                    req,
	ols_rsp_if.source                  rsp,
	output ols_pkg::ram_req_t          ram,
	input  logic [ols_pkg::DATA_W-1:0] rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SHIFT_UP,
		S_PUT,
		S_SHIFT_DN,
		S_RDWAIT,
		S_SCAN,
		S_FINISH
	} state_t;

	localparam logic [ols_pkg::CNT_W-1:0] FULL = ols_pkg::CNT_W'(ols_pkg::DEPTH);
	localparam logic [ols_pkg::CNT_W-1:0] ONE  = ols_pkg::CNT_W'(1);
	localparam logic [ols_pkg::CNT_W-1:0] TWO  = ols_pkg::CNT_W'(2);

	state_t                         state_q, state_d;
	logic [ols_pkg::OP_W-1:0]       op_q;
	logic [ols_pkg::POS_W-1:0]      pos_q;
	logic [ols_pkg::DATA_W-1:0]     val_q;
	logic [ols_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [ols_pkg::CNT_W-1:0]      k_q, k_d;
	ols_pkg::res_t                  res_q, res_d;
	ols_pkg::res_t                  out_q, out_d;
	logic                           out_valid_q, out_valid_d;
	logic [ols_pkg::CMP_W-1:0]      pos_ext, cnt_ext, k_ext;

	assign pos_ext = ols_pkg::CMP_W'(pos_q);
	assign cnt_ext = ols_pkg::CMP_W'(cnt_q);
	assign k_ext   = ols_pkg::CMP_W'(k_q);

	// handshake and result ports
	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.ok          = out_q.ok;
	assign rsp.read_data   = out_q.read_data;
	assign rsp.found_index = out_q.found_index;
	assign rsp.count       = out_q.count;

	// next state, memory accesses and result updates
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		k_d         = k_q;
		res_d       = res_q;
		out_d       = out_q;
		out_valid_d = out_valid_q;
		ram         = '0;

		if (out_valid_q && rsp.ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_d   = '0;
				state_d = S_FINISH;
				unique case (op_q)
					ols_pkg::OP_APPEND: begin
						if (cnt_q < FULL) begin
							ram.we       = 1'b1;
							ram.waddr    = ols_pkg::IDX_W'(cnt_q);
							ram.wdata    = val_q;
							cnt_d        = cnt_q + ONE;
							res_d.ok     = 1'b1;
						end
					end
					ols_pkg::OP_INSERT: begin
						if (cnt_q < FULL && pos_ext <= cnt_ext) begin
							if (pos_ext == cnt_ext) begin
								ram.we    = 1'b1;
								ram.waddr = ols_pkg::IDX_W'(pos_q);
								ram.wdata = val_q;
								cnt_d     = cnt_q + ONE;
								res_d.ok  = 1'b1;
							end else begin
								ram.raddr = ols_pkg::IDX_W'(cnt_q - ONE);
								k_d       = cnt_q;
								state_d   = S_SHIFT_UP;
							end
						end
					end
					ols_pkg::OP_REMOVE: begin
						if (pos_ext < cnt_ext) begin
							if (pos_ext + ols_pkg::CMP_W'(1) == cnt_ext) begin
								cnt_d    = cnt_q - ONE;
								res_d.ok = 1'b1;
							end else begin
								ram.raddr = ols_pkg::IDX_W'(pos_q + ols_pkg::POS_W'(1));
								k_d       = ols_pkg::CNT_W'(pos_q);
								state_d   = S_SHIFT_DN;
							end
						end
					end
					ols_pkg::OP_READ: begin
						if (pos_ext < cnt_ext) begin
							ram.raddr = ols_pkg::IDX_W'(pos_q);
							state_d   = S_RDWAIT;
						end
					end
					ols_pkg::OP_FIND: begin
						if (cnt_q != '0) begin
							ram.raddr = '0;
							k_d       = '0;
							state_d   = S_SCAN;
						end
					end
					ols_pkg::OP_CLEAR: begin
						cnt_d    = '0;
						res_d.ok = 1'b1;
					end
					default: begin
					end
				endcase
			end
			// move entry k-1 up to k, walking down toward the insert point
			S_SHIFT_UP: begin
				ram.we    = 1'b1;
				ram.waddr = ols_pkg::IDX_W'(k_q);
				ram.wdata = rdata;
				if (k_ext == pos_ext + ols_pkg::CMP_W'(1)) begin
					state_d = S_PUT;
				end else begin
					ram.raddr = ols_pkg::IDX_W'(k_q - TWO);
					k_d       = k_q - ONE;
				end
			end
			S_PUT: begin
				ram.we    = 1'b1;
				ram.waddr = ols_pkg::IDX_W'(pos_q);
				ram.wdata = val_q;
				cnt_d     = cnt_q + ONE;
				res_d.ok  = 1'b1;
				state_d   = S_FINISH;
			end
			// move entry k+1 down to k, walking up to the tail
			S_SHIFT_DN: begin
				ram.we    = 1'b1;
				ram.waddr = ols_pkg::IDX_W'(k_q);
				ram.wdata = rdata;
				if (k_q + TWO == cnt_q) begin
					cnt_d    = cnt_q - ONE;
					res_d.ok = 1'b1;
					state_d  = S_FINISH;
				end else begin
					ram.raddr = ols_pkg::IDX_W'(k_q + TWO);
					k_d       = k_q + ONE;
				end
			end
			S_RDWAIT: begin
				res_d.read_data = rdata;
				res_d.ok        = 1'b1;
				state_d         = S_FINISH;
			end
			// linear search, first match wins
			S_SCAN: begin
				if (rdata == val_q) begin
					res_d.ok          = 1'b1;
					res_d.found_index = ols_pkg::FIDX_W'(k_q);
					state_d           = S_FINISH;
				end else if (k_q + ONE == cnt_q) begin
					state_d = S_FINISH;
				end else begin
					ram.raddr = ols_pkg::IDX_W'(k_q + ONE);
					k_d       = k_q + ONE;
				end
			end
			// hand the result to the output register once it is free
			S_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_d       = res_q;
					out_d.count = ols_pkg::COUNT_W'(cnt_q);
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_q       <= out_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			op_q  <= req.opcode;
			pos_q <= req.position;
			val_q <= req.value;
		end
		k_q   <= k_d;
		res_q <= res_d;
	end

endmodule

// ===== rtl/ordered_list_store.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store
// Fixed-capacity ordered list of signed 32-bit entries held in a RAM.
// ----------------------------------------------------------------------------
// The list keeps up to DEPTH entries in a single synchronous RAM with one
// write and one read port, and handles one item at a time. Every item gives
// exactly one response carrying ok, read data, found index and the count
// after the operation. The RAM moves one entry per cycle, so an insert or a
// remove shifts every entry behind its position, and a find reads entries in
// order until the first match or the end of the list. A finished response
// waits in an output register, so a new item is taken while the previous
// response is still pending.
module ordered_list_store (
	input  logic      clk,
	input  logic      arst_n,
	ols_req_if.sink   req,
	ols_rsp_if.source rsp
);

	ols_pkg::ram_req_t          ram;
	logic [ols_pkg::DATA_W-1:0] rdata;

	// sequencer
	ols_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ram    (ram),
		.rdata  (rdata)
	);

	// entry storage
	ols_ram #(
		.WIDTH (ols_pkg::DATA_W),
		.DEPTH (ols_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

endmodule

// ===== rtl/ols_checker.sv =====
// ----------------------------------------------------------------------------
// ols_checker
// Port-level assertions for the ordered list store, bound to the top level.
// ----------------------------------------------------------------------------
module ols_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic                              rsp_ok,
	input logic signed [ols_pkg::DATA_W-1:0] rsp_read_data,
	input logic [ols_pkg::FIDX_W-1:0]        rsp_found_index,
	input logic [ols_pkg::COUNT_W-1:0]       rsp_count
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok)
			&& $stable(rsp_read_data) && $stable(rsp_found_index) && $stable(rsp_count))
		else $error("response changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in work");

	// count never exceeds capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= ols_pkg::COUNT_W'(ols_pkg::DEPTH))
		else $error("count above capacity");

	// a failed operation carries zero data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_read_data == '0 && rsp_found_index == '0)
		else $error("failed response with nonzero data");

endmodule

bind ordered_list_store ols_checker u_ols_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_ok          (rsp.ok),
	.rsp_read_data   (rsp.read_data),
	.rsp_found_index (rsp.found_index),
	.rsp_count       (rsp.count)
);
